[hw/rtl/wlcr_pkg.sv]
// shared types, codes and control store for the wear leveling counter ring
`default_nettype none

package wlcr_pkg;

    localparam int WLCR_RING_SLOTS = 128;

    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [31:0] ZERO_WORD   = 32'h0000_0000;

    localparam int STEP_W = 4;

    // wait conditions
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_OUT  = 2'd2;

    // write data select
    localparam logic [1:0] D_ZERO = 2'd0;
    localparam logic [1:0] D_ONES = 2'd1;
    localparam logic [1:0] D_RAW  = 2'd2;
    localparam logic [1:0] D_NEW  = 2'd3;

    // write address select
    localparam logic [1:0] A_CNT  = 2'd0;
    localparam logic [1:0] A_SLOT = 2'd1;
    localparam logic [1:0] A_PTR  = 2'd2;

    // pointer and value update select
    localparam logic [1:0] U_NONE  = 2'd0;
    localparam logic [1:0] U_SCAN  = 2'd1;
    localparam logic [1:0] U_WRITE = 2'd2;
    localparam logic [1:0] U_CLEAR = 2'd3;

    // jump conditions
    localparam logic [2:0] J_NEXT       = 3'd0;
    localparam logic [2:0] J_ALWAYS     = 3'd1;
    localparam logic [2:0] J_NOT_LAST   = 3'd2;
    localparam logic [2:0] J_NOT_ERASED = 3'd3;
    localparam logic [2:0] J_DISPATCH   = 3'd4;

    // program steps
    localparam logic [STEP_W-1:0] S_INIT      = 4'd0;
    localparam logic [STEP_W-1:0] S_IDLE      = 4'd1;
    localparam logic [STEP_W-1:0] S_LOAD      = 4'd2;
    localparam logic [STEP_W-1:0] S_REC0      = 4'd3;
    localparam logic [STEP_W-1:0] S_WRITE     = 4'd4;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd5;
    localparam logic [STEP_W-1:0] S_CLEAR_FIN = 4'd6;
    localparam logic [STEP_W-1:0] S_DONE      = 4'd7;
    localparam logic [STEP_W-1:0] S_SCAN      = 4'd8;
    localparam logic [STEP_W-1:0] S_SCAN_TAIL = 4'd9;
    localparam logic [STEP_W-1:0] S_SCAN_FIN  = 4'd10;
    localparam logic [STEP_W-1:0] S_TO_CLEAR  = 4'd11;

    typedef struct packed {
        logic [1:0]        wait_sel;
        logic              mem_we;
        logic [1:0]        wdata_sel;
        logic [1:0]        addr_sel;
        logic              mem_re;
        logic              cnt_inc;
        logic              capture;
        logic              scan_en;
        logic [1:0]        upd_sel;
        logic              out_load;
        logic [2:0]        jump;
        logic [STEP_W-1:0] target;
    } wlcr_cw_t;

    typedef struct packed {
        logic cnt_last;
        logic erased;
        logic out_busy;
    } wlcr_dp_status_t;

    function automatic wlcr_cw_t wlcr_ucode(input logic [STEP_W-1:0] step);
        wlcr_cw_t cw;
        cw = '0;
        unique case (step)
            S_INIT:
            begin
                cw.mem_we    = 1'b1;
                cw.wdata_sel = D_ONES;
                cw.addr_sel  = A_CNT;
                cw.cnt_inc   = 1'b1;
                cw.jump      = J_NOT_LAST;
                cw.target    = S_INIT;
            end
            S_IDLE:
            begin
                cw.wait_sel = W_IN;
                cw.capture  = 1'b1;
                cw.jump     = J_DISPATCH;
                cw.target   = S_LOAD;
            end
            S_LOAD:
            begin
                cw.mem_we    = 1'b1;
                cw.wdata_sel = D_RAW;
                cw.addr_sel  = A_SLOT;
                cw.jump      = J_ALWAYS;
                cw.target    = S_DONE;
            end
            S_REC0:
            begin
                cw.mem_re  = 1'b1;
                cw.cnt_inc = 1'b1;
                cw.jump    = J_ALWAYS;
                cw.target  = S_SCAN;
            end
            S_WRITE:
            begin
                cw.mem_we    = 1'b1;
                cw.wdata_sel = D_NEW;
                cw.addr_sel  = A_PTR;
                cw.upd_sel   = U_WRITE;
                cw.jump      = J_ALWAYS;
                cw.target    = S_DONE;
            end
            S_CLEAR:
            begin
                cw.mem_we    = 1'b1;
                cw.wdata_sel = D_ZERO;
                cw.addr_sel  = A_CNT;
                cw.cnt_inc   = 1'b1;
                cw.jump      = J_NOT_LAST;
                cw.target    = S_CLEAR;
            end
            S_CLEAR_FIN:
            begin
                cw.upd_sel = U_CLEAR;
                cw.jump    = J_NEXT;
            end
            S_DONE:
            begin
                cw.wait_sel = W_OUT;
                cw.out_load = 1'b1;
                cw.jump     = J_ALWAYS;
                cw.target   = S_IDLE;
            end
            S_SCAN:
            begin
                cw.mem_re  = 1'b1;
                cw.cnt_inc = 1'b1;
                cw.scan_en = 1'b1;
                cw.jump    = J_NOT_LAST;
                cw.target  = S_SCAN;
            end
            S_SCAN_TAIL:
            begin
                cw.scan_en = 1'b1;
                cw.jump    = J_NEXT;
            end
            S_SCAN_FIN:
            begin
                cw.upd_sel = U_SCAN;
                cw.jump    = J_NOT_ERASED;
                cw.target  = S_DONE;
            end
            S_TO_CLEAR:
            begin
                cw.jump   = J_ALWAYS;
                cw.target = S_CLEAR;
            end
            default:
            begin
                cw.jump   = J_ALWAYS;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wlcr_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module wlcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/wlcr_seq.sv]
// microprogram sequencer: step counter, control store and jump logic
`default_nettype none

module wlcr_seq (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [1:0]               action,
    input  wire wlcr_pkg::wlcr_dp_status_t dp_status,
    output wlcr_pkg::wlcr_cw_t            cw,
    output logic                          go
);

    import wlcr_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;

    assign cw       = wlcr_ucode(step_reg);
    assign step_inc = step_reg + STEP_W'(1);

    always_comb
    begin
        go = 1'b1;
        if (cw.wait_sel == W_IN && !in_valid)
        begin
            go = 1'b0;
        end
        if (cw.wait_sel == W_OUT && dp_status.out_busy)
        begin
            go = 1'b0;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            unique case (cw.jump)
                J_NEXT:       step_next = step_inc;
                J_ALWAYS:     step_next = cw.target;
                J_NOT_LAST:   step_next = dp_status.cnt_last ? step_inc : cw.target;
                J_NOT_ERASED: step_next = dp_status.erased ? step_inc : cw.target;
                J_DISPATCH:   step_next = cw.target + {{(STEP_W-2){1'b0}}, action};
                default:      step_next = step_inc;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wlcr_datapath.sv]
// datapath: request capture, slot counter, scan unit, pointer and result register
`default_nettype none

module wlcr_datapath #(
    parameter int RING_SLOTS = wlcr_pkg::WLCR_RING_SLOTS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wlcr_pkg::wlcr_cw_t            cw,
    input  wire logic                          go,
    input  wire logic [6:0]                    slot_index,
    input  wire logic [31:0]                   raw_word,
    input  wire logic [30:0]                   count_value,
    input  wire logic                          lock_flag,
    input  wire logic                          commit_ok,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [6:0]                         next_slot,
    output logic [30:0]                        current_count,
    output logic                               current_lock,
    output logic                               status,
    output logic                               ring_cleared,
    output wlcr_pkg::wlcr_dp_status_t          dp_status,
    output logic                               ram_we,
    output logic [$clog2(RING_SLOTS)-1:0]      ram_waddr,
    output logic [31:0]                        ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(RING_SLOTS)-1:0]      ram_raddr,
    input  wire logic [31:0]                   ram_rdata
);

    import wlcr_pkg::*;

    localparam int PW = $clog2(RING_SLOTS);
    localparam logic [PW-1:0] LAST_IDX = PW'(RING_SLOTS - 1);

    logic [PW-1:0] cnt_reg;
    logic [PW-1:0] cnt_next;
    logic [PW-1:0] rd_idx_reg;

    logic [6:0]  slot_reg;
    logic [31:0] raw_reg;
    logic [30:0] count_reg;
    logic        lock_reg;
    logic        commit_reg;

    logic [30:0]   prev_reg;
    logic [30:0]   best_reg;
    logic          best_lock_reg;
    logic [PW-1:0] best_at_reg;
    logic          erased_reg;

    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [31:0]   latest_reg;
    logic [31:0]   latest_next;
    logic          status_reg;
    logic          status_next;
    logic          cleared_reg;
    logic          cleared_next;

    logic          out_valid_reg;
    logic [6:0]    out_slot_reg;
    logic [31:0]   out_word_reg;
    logic          out_status_reg;
    logic          out_cleared_reg;

    logic [PW+6:0] slot_wide;
    logic [PW+6:0] ptr_wide;
    logic          slot_ok;
    logic [31:0]   new_word;
    logic [30:0]   scan_val;
    logic [31:0]   prev_inc;
    logic          scan_hit;
    logic [PW-1:0] ptr_adv;
    logic [PW-1:0] best_adv;

    assign slot_wide = {{PW{1'b0}}, slot_reg};
    assign ptr_wide  = {7'd0, ptr_reg};
    assign slot_ok   = 32'(slot_reg) < 32'(RING_SLOTS);
    assign new_word  = {lock_reg, count_reg};
    assign scan_val  = ram_rdata[30:0];
    assign prev_inc  = {1'b0, prev_reg} + 32'd1;
    assign scan_hit  = (scan_val > best_reg) && (prev_inc == {1'b0, scan_val});
    assign ptr_adv   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + PW'(1);
    assign best_adv  = (best_at_reg == LAST_IDX) ? '0 : best_at_reg + PW'(1);
    assign cnt_next  = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + PW'(1);

    always_comb
    begin
        case (cw.addr_sel)
            A_SLOT:  ram_waddr = slot_wide[PW-1:0];
            A_PTR:   ram_waddr = ptr_reg;
            default: ram_waddr = cnt_reg;
        endcase
        case (cw.wdata_sel)
            D_ONES:  ram_wdata = ERASED_WORD;
            D_RAW:   ram_wdata = raw_reg;
            D_NEW:   ram_wdata = new_word;
            default: ram_wdata = ZERO_WORD;
        endcase
    end

    assign ram_we    = go && cw.mem_we && (cw.addr_sel != A_SLOT || slot_ok);
    assign ram_re    = go && cw.mem_re;
    assign ram_raddr = cnt_reg;

    always_comb
    begin
        ptr_next     = ptr_reg;
        latest_next  = latest_reg;
        status_next  = status_reg;
        cleared_next = cleared_reg;
        if (go && cw.capture)
        begin
            status_next  = 1'b0;
            cleared_next = 1'b0;
        end
        if (go)
        begin
            case (cw.upd_sel)
                U_SCAN:
                begin
                    ptr_next    = best_adv;
                    latest_next = {best_lock_reg, best_reg};
                end
                U_WRITE:
                begin
                    if (commit_reg)
                    begin
                        ptr_next    = ptr_adv;
                        latest_next = new_word;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                U_CLEAR:
                begin
                    cleared_next = 1'b1;
                    if (commit_reg)
                    begin
                        ptr_next    = '0;
                        latest_next = ZERO_WORD;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            latest_reg    <= ZERO_WORD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go && cw.cnt_inc)
            begin
                cnt_reg <= cnt_next;
            end
            ptr_reg    <= ptr_next;
            latest_reg <= latest_next;
            if (go && cw.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        cleared_reg <= cleared_next;
        if (go && cw.capture)
        begin
            slot_reg   <= slot_index;
            raw_reg    <= raw_word;
            count_reg  <= count_value;
            lock_reg   <= lock_flag;
            commit_reg <= commit_ok;
        end
        if (go && cw.mem_re)
        begin
            rd_idx_reg <= cnt_reg;
        end
        if (go && cw.scan_en)
        begin
            prev_reg <= scan_val;
            if (rd_idx_reg == '0)
            begin
                best_reg      <= scan_val;
                best_lock_reg <= ram_rdata[31];
                best_at_reg   <= '0;
                erased_reg    <= (ram_rdata == ERASED_WORD);
            end
            else
            begin
                if (ram_rdata == ERASED_WORD)
                begin
                    erased_reg <= 1'b1;
                end
                if (scan_hit)
                begin
                    best_reg      <= scan_val;
                    best_lock_reg <= ram_rdata[31];
                    best_at_reg   <= rd_idx_reg;
                end
            end
        end
        if (go && cw.out_load)
        begin
            out_slot_reg    <= ptr_wide[6:0];
            out_word_reg    <= latest_reg;
            out_status_reg  <= status_reg;
            out_cleared_reg <= cleared_reg;
        end
    end

    assign dp_status.cnt_last = (cnt_reg == LAST_IDX);
    assign dp_status.erased   = erased_reg;
    assign dp_status.out_busy = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign next_slot     = out_slot_reg;
    assign current_count = out_word_reg[30:0];
    assign current_lock  = out_word_reg[31];
    assign status        = out_status_reg;
    assign ring_cleared  = out_cleared_reg;

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= LAST_IDX)
        else $error("write pointer left the ring");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.wait_sel == W_IN) |-> (cnt_reg == '0))
        else $error("slot counter not rewound between requests");

    a_status_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cw.out_load && status_reg) |-> !commit_reg)
        else $error("failure status without failed commit");

    a_clear_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cw.out_load && cleared_reg && commit_reg)
            |-> (ptr_reg == '0 && latest_reg == ZERO_WORD))
        else $error("committed clear left pointer or value set");

endmodule

`default_nettype wire

[hw/rtl/wear_leveling_counter_ring_unit.sv]
// top level of the wear leveling counter ring
`default_nettype none

// Keeps a ring of RING_SLOTS 32-bit words (31-bit count, lock in bit 31) in one ram and
// returns one result per request: next write slot, current count and lock, commit status
// and a ring-cleared flag. A small microprogram drives the datapath, and the ram's single
// write port and single read port set the timing: one slot is touched per cycle. Load
// writes the raw word into the named slot and write stores the new word at the write
// pointer; clear zeroes every slot, and recover scans every slot and, when it finds an
// erased slot, also clears the ring. After reset an initialization pass writes the
// erased pattern into every slot, during which no request is accepted. A finished result
// waits in an output register, so the next request is taken while it is pending.
module wear_leveling_counter_ring_unit #(
    parameter int RING_SLOTS = wlcr_pkg::WLCR_RING_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [6:0]  slot_index,
    input  wire logic [31:0] raw_word,
    input  wire logic [30:0] count_value,
    input  wire logic        lock_flag,
    input  wire logic        commit_ok,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       next_slot,
    output logic [30:0]      current_count,
    output logic             current_lock,
    output logic             status,
    output logic             ring_cleared
);

    import wlcr_pkg::*;

    localparam int PW = $clog2(RING_SLOTS);

    wlcr_cw_t        cw;
    wlcr_dp_status_t dp_status;
    logic            go;
    logic            ram_we;
    logic [PW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [PW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    assign in_ready = (cw.wait_sel == W_IN);

    wlcr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .dp_status (dp_status),
        .cw        (cw),
        .go        (go)
    );

    wlcr_datapath #(
        .RING_SLOTS (RING_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .go            (go),
        .slot_index    (slot_index),
        .raw_word      (raw_word),
        .count_value   (count_value),
        .lock_flag     (lock_flag),
        .commit_ok     (commit_ok),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .next_slot     (next_slot),
        .current_count (current_count),
        .current_lock  (current_lock),
        .status        (status),
        .ring_cleared  (ring_cleared),
        .dp_status     (dp_status),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    wlcr_ram #(
        .WIDTH (32),
        .DEPTH (RING_SLOTS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[bench/tb_wear_leveling_counter_ring_unit.sv]
// testbench for the wear leveling counter ring unit: directed and random requests checked against a predictor

localparam int RING_SLOTS = wlcr_pkg::WLCR_RING_SLOTS;

typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RECOVER = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_CLEAR   = 2'd3
} ring_action_e;

typedef struct packed {
    logic [6:0]  slot;
    logic [30:0] count;
    logic        lock;
    logic        status;
    logic        cleared;
} ring_result_t;

class counter_ring_tracker;
    logic [31:0]  ring [RING_SLOTS];
    int           write_ptr;
    logic [31:0]  latest;
    ring_result_t pending [$];
    int           mismatches;
    int           results_seen;

    function new();
        foreach (ring[i])
            ring[i] = wlcr_pkg::ERASED_WORD;
        write_ptr    = 0;
        latest       = '0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // zero every slot, returns the failed-commit bit
    function logic wipe_ring(logic commit);
        foreach (ring[i])
            ring[i] = '0;
        if (commit)
        begin
            write_ptr = 0;
            latest    = '0;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void note_request(logic [1:0] act, logic [6:0] slot, logic [31:0] raw,
                               logic [30:0] cnt, logic lock, logic commit);
        ring_result_t r;
        logic [30:0]  prev;
        logic [30:0]  best;
        logic         best_lock;
        int           best_at;
        logic         erased;
        logic [31:0]  word;
        int           p;
        r = '0;
        case (act)
            ACT_LOAD:
            begin
                if (int'(slot) < RING_SLOTS)
                    ring[slot] = raw;
            end
            ACT_RECOVER:
            begin
                prev      = ring[0][30:0];
                best      = prev;
                best_lock = ring[0][31];
                best_at   = 0;
                erased    = (ring[0] == wlcr_pkg::ERASED_WORD);
                for (int i = 1; i < RING_SLOTS; i++)
                begin
                    if (ring[i] == wlcr_pkg::ERASED_WORD)
                        erased = 1'b1;
                    if (ring[i][30:0] > best && {1'b0, prev} + 32'd1 == {1'b0, ring[i][30:0]})
                    begin
                        best      = ring[i][30:0];
                        best_lock = ring[i][31];
                        best_at   = i;
                    end
                    prev = ring[i][30:0];
                end
                write_ptr = (best_at + 1) % RING_SLOTS;
                latest    = {best_lock, best};
                if (erased)
                begin
                    r.status  = wipe_ring(commit);
                    r.cleared = 1'b1;
                end
            end
            ACT_WRITE:
            begin
                word    = {lock, cnt};
                p       = write_ptr % RING_SLOTS;
                ring[p] = word;
                if (commit)
                begin
                    write_ptr = (p + 1) % RING_SLOTS;
                    latest    = word;
                end
                else
                    r.status = 1'b1;
            end
            ACT_CLEAR:
            begin
                r.status  = wipe_ring(commit);
                r.cleared = 1'b1;
            end
        endcase
        r.slot  = 7'(write_ptr);
        r.count = latest[30:0];
        r.lock  = latest[31];
        pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task check_result(ring_result_t got);
        ring_result_t want;
        results_seen++;
        if (pending.size() == 0)
        begin
            report_mismatch("result with no request pending");
            return;
        end
        want = pending.pop_front();
        if (got.slot !== want.slot)
            report_mismatch($sformatf("next_slot got %0d expected %0d", got.slot, want.slot));
        if (got.count !== want.count)
            report_mismatch($sformatf("current_count got %0h expected %0h",
                                      got.count, want.count));
        if (got.lock !== want.lock)
            report_mismatch($sformatf("current_lock got %0b expected %0b", got.lock, want.lock));
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b", got.status, want.status));
        if (got.cleared !== want.cleared)
            report_mismatch($sformatf("ring_cleared got %0b expected %0b",
                                      got.cleared, want.cleared));
    endtask
endclass

module tb_wear_leveling_counter_ring_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENDER_IDLE [4]    = '{0, 77, 0, 38};
    localparam int RECEIVER_STALL [4] = '{0, 0, 77, 38};
    localparam int PHASE_ITEMS        = 175;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [6:0]  slot_index;
    logic [31:0] raw_word;
    logic [30:0] count_value;
    logic        lock_flag;
    logic        commit_ok;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  next_slot;
    logic [30:0] current_count;
    logic        current_lock;
    logic        status;
    logic        ring_cleared;

    counter_ring_tracker tracker;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_len       = 0;
    int requests_sent      = 0;

    wear_leveling_counter_ring_unit #(
        .RING_SLOTS(RING_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .slot_index   (slot_index),
        .raw_word     (raw_word),
        .count_value  (count_value),
        .lock_flag    (lock_flag),
        .commit_ok    (commit_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .next_slot    (next_slot),
        .current_count(current_count),
        .current_lock (current_lock),
        .status       (status),
        .ring_cleared (ring_cleared)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1)
            tracker.note_request(action, slot_index, raw_word, count_value, lock_flag, commit_ok);
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            tracker.check_result('{next_slot, current_count, current_lock, status, ring_cleared});
    end

    initial
    begin : receiver
        int remaining;
        remaining = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                remaining    = hold_off_len;
                hold_off_len = 0;
            end
            if (remaining > 0)
            begin
                out_ready <= 1'b0;
                remaining--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

    task automatic send_request(input logic [1:0] act, input logic [6:0] slot,
                                input logic [31:0] raw, input logic [30:0] cnt,
                                input logic lock, input logic commit);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        slot_index  <= slot;
        raw_word    <= raw;
        count_value <= cnt;
        lock_flag   <= lock;
        commit_ok   <= commit;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic do_load(input logic [6:0] slot, input logic [31:0] raw);
        send_request(ACT_LOAD, slot, raw, 31'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic do_write(input logic [30:0] cnt, input logic lock, input logic commit);
        send_request(ACT_WRITE, 7'($urandom), $urandom, cnt, lock, commit);
    endtask

    task automatic do_recover(input logic commit);
        send_request(ACT_RECOVER, 7'($urandom), $urandom, 31'($urandom), 1'($urandom), commit);
    endtask

    task automatic do_clear(input logic commit);
        send_request(ACT_CLEAR, 7'($urandom), $urandom, 31'($urandom), 1'($urandom), commit);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (tracker.results_seen < requests_sent)
            @(posedge clk);
    endtask

    function automatic logic [30:0] pick_base(int len);
        case ($urandom_range(0, 2))
            0: return 31'($urandom_range(0, 20));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, len));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] noisy_word();
        return ($urandom_range(0, 4) == 0) ? wlcr_pkg::ERASED_WORD : $urandom;
    endfunction

    task automatic random_burst();
        int          pick;
        int          len;
        int          start;
        logic [30:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // counting run laid down by writes, then recovery
            do_clear(1'($urandom_range(0, 9) != 0));
            len  = ($urandom_range(0, 49) == 0) ? $urandom_range(RING_SLOTS, RING_SLOTS + 12)
                                                : $urandom_range(1, 12);
            base = pick_base(len);
            for (int k = 0; k < len; k++)
                do_write(base + 31'(k), 1'($urandom), 1'($urandom_range(0, 9) != 0));
            if ($urandom_range(0, 3) == 0)
                do_load(7'($urandom), noisy_word());
            do_recover(1'($urandom));
        end
        else if (pick < 65)
        begin
            // counting runs laid down by loads at random slots
            do_clear(1'($urandom_range(0, 9) != 0));
            repeat ($urandom_range(1, 2))
            begin
                start = $urandom_range(0, RING_SLOTS - 1);
                len   = $urandom_range(2, 10);
                base  = pick_base(len);
                for (int k = 0; k < len; k++)
                    do_load(7'(start + k), {1'($urandom), base + 31'(k)});
            end
            if ($urandom_range(0, 4) == 0)
                do_load(7'($urandom), wlcr_pkg::ERASED_WORD);
            do_recover(1'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                send_request(2'($urandom), 7'($urandom), noisy_word(), 31'($urandom),
                             1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        int target;
        tracker     = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        action      <= ACT_LOAD;
        slot_index  <= '0;
        raw_word    <= '0;
        count_value <= '0;
        lock_flag   <= 1'b0;
        commit_ok   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        do_recover(1'b1);
        do_write(31'h7FFF_FFFF, 1'b1, 1'b1);
        do_write(31'h0, 1'b0, 1'b0);
        do_load(7'd127, wlcr_pkg::ERASED_WORD);
        do_load(7'd0, 32'h0000_0000);
        do_recover(1'b0);
        do_clear(1'b0);
        do_clear(1'b1);
        do_load(7'd0, 32'h8000_0005);
        do_load(7'd1, 32'h0000_0006);
        do_load(7'd2, 32'h8000_0007);
        do_recover(1'b0);
        do_load(7'd126, 32'h7FFF_FFFE);
        do_load(7'd127, 32'h7FFF_FFFF);
        do_recover(1'b1);
        do_clear(1'b1);
        do_load(7'd125, 32'h8000_0010);
        do_load(7'd126, 32'h8000_0011);
        do_recover(1'b1);
        do_write(31'h0000_0012, 1'b0, 1'b1);
        do_write(31'h5555_AAAA, 1'b1, 1'b1);

        target = requests_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = SENDER_IDLE[phase];
            receiver_stall_pct = RECEIVER_STALL[phase];
            target += PHASE_ITEMS;
            while (requests_sent < target)
                random_burst();
            if (phase == 0)
            begin
                // long receiver hold-off while requests keep coming, then a full drain
                hold_off_len = 300;
                repeat (12)
                    do_write(31'($urandom), 1'($urandom), 1'b1);
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (2 * RING_SLOTS + 16) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/wlcr_pkg.sv
hw/rtl/wlcr_ram.sv
hw/rtl/wlcr_seq.sv
hw/rtl/wlcr_datapath.sv
hw/rtl/wear_leveling_counter_ring_unit.sv
bench/tb_wear_leveling_counter_ring_unit.sv
